// ===== design/binary_majority_filter_3x3_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the majority filter RTL
// ---------------------------------------------------------------------------
`ifndef BINARY_MAJORITY_FILTER_3X3_ASSERT_SVH
`define BINARY_MAJORITY_FILTER_3X3_ASSERT_SVH

// plain invariant, checked at every rising clock edge outside reset
`define BMF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define BMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/bmf3x3_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmf3x3_pkg
// Types, constants and the 3x3 majority decision shared by the filter.
// ---------------------------------------------------------------------------
package bmf3x3_pkg;

  localparam int SIDE_W      = 6;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd32;
  localparam int MAX_RESULTS = 33;
  localparam int GRP_W       = 6;
  localparam int HELD_W      = 6;
  localparam int TOT_W       = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  // register index, taken from paddr[2]
  localparam logic REG_SIDE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MID,
    ST_EDGE,
    ST_FLUSH
  } bk_state_e;

  typedef struct packed {
    logic [8:0] win;
    logic       top_ok;
    logic       mid_left_ok;
    logic       edge_left_ok;
    logic       has_mid;
    logic       has_edge;
    logic       flush;
  } job_ctl_t;

  // window: three 3-bit columns, oldest lowest; bit j of a column is row j
  function automatic logic majority(input logic [8:0] win, input logic [2:0] colok,
                                    input logic [2:0] rowok);
    logic [3:0] ones;
    logic [3:0] cnt;
    logic       m;
    int         k;
    int         j;
    ones = '0;
    cnt  = '0;
    for (k = 0; k < 3; k++) begin
      for (j = 0; j < 3; j++) begin
        m    = colok[k] & rowok[j];
        cnt  = cnt + 4'(m);
        ones = ones + 4'(m & win[3*k+j]);
      end
    end
    return ({ones, 1'b0} >= {1'b0, cnt});
  endfunction

endpackage

// ===== design/bmf3x3_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmf3x3_fifo
// Small register queue with synchronous clear, data visible at the head.
// ---------------------------------------------------------------------------
module bmf3x3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  always_comb begin
    full_o  = (cnt_q == NW'(DEPTH));
    valid_o = (cnt_q != '0);
    rdata_o = mem_q[rd_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    wr_d    = wr_q;
    rd_d    = rd_q;
    cnt_d   = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (clr_i) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/bmf3x3_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmf3x3_front
// Takes pixels, keeps line stores and window, and queues the result jobs and run sizes.
// ---------------------------------------------------------------------------
`include "binary_majority_filter_3x3_assert.svh"

module bmf3x3_front
  import bmf3x3_pkg::*;
#(
  parameter int MAX_SIDE = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic [SIDE_W-1:0]     side_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  pixel_i,
  output logic                  job_push_o,
  output job_ctl_t              job_ctl_o,
  output logic [2*MAX_SIDE-1:0] job_snap_o,
  input  logic                  job_full_i,
  output logic                  grp_push_o,
  output logic [GRP_W-1:0]      grp_size_o,
  input  logic                  grp_full_i
);

  localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  logic [CW-1:0]            row_q, row_d, col_q, col_d;
  logic [MAX_SIDE-1:0][1:0] line_q, line_d;
  logic [8:0]               win_q, win_d;
  logic [HELD_W-1:0]        held_q, held_d;
  logic                     fire;
  logic [1:0]               old_w;
  logic [2:0]               new_col;
  logic [SIDE_W-1:0]        row_w, col_w, side_m1;
  logic                     has_mid, has_edge, img_end;
  logic [TOT_W-1:0]         own, tot;
  logic [GRP_W-1:0]         grp_n;

  always_comb begin
    in_ready_o = !job_full_i && !grp_full_i;
    fire       = in_valid_i && in_ready_o;
    row_w      = SIDE_W'(row_q);
    col_w      = SIDE_W'(col_q);
    side_m1    = side_i - SIDE_W'(1);

    // line store: bit 1 older row, bit 0 newer row
    old_w          = line_q[col_q];
    new_col        = {pixel_i, old_w[0], old_w[1]};
    line_d         = line_q;
    line_d[col_q]  = {old_w[0], pixel_i};
    win_d          = {new_col, win_q[8:3]};

    has_mid  = (row_w != '0) && (col_w != '0);
    has_edge = (row_w != '0) && (col_w == side_m1);
    img_end  = (row_w == side_m1) && (col_w == side_m1);

    // results held back from an over-long burst open the next run
    own = TOT_W'(has_mid) + TOT_W'(has_edge) + (img_end ? TOT_W'(side_i) : '0);
    tot = TOT_W'(held_q) + own;
    if (tot > TOT_W'(MAX_RESULTS)) begin
      grp_n = GRP_W'(MAX_RESULTS);
    end else begin
      grp_n = GRP_W'(tot);
    end
    held_d = HELD_W'(tot - TOT_W'(grp_n));

    row_d = row_q;
    col_d = col_q + CW'(1);
    if (col_w == side_m1) begin
      col_d = '0;
      row_d = (row_w == side_m1) ? '0 : row_q + CW'(1);
    end

    job_ctl_o.win          = win_d;
    job_ctl_o.top_ok       = (row_w >= SIDE_W'(2));
    job_ctl_o.mid_left_ok  = (col_w >= SIDE_W'(2));
    job_ctl_o.edge_left_ok = (col_w != '0);
    job_ctl_o.has_mid      = has_mid;
    job_ctl_o.has_edge     = has_edge;
    job_ctl_o.flush        = img_end;
    job_snap_o             = line_d;

    job_push_o = fire && (has_mid || has_edge || img_end);
    grp_push_o = fire && (grp_n != '0);
    grp_size_o = grp_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      held_q <= '0;
    end else if (clr_i) begin
      row_q  <= '0;
      col_q  <= '0;
      held_q <= '0;
    end else if (fire) begin
      row_q  <= row_d;
      col_q  <= col_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      win_q  <= '0;
    end else if (fire) begin
      line_q <= line_d;
      win_q  <= win_d;
    end
  end

  `BMF_ASSERT(a_held_bound, clk_i, rst_ni, held_q <= HELD_W'(MAX_SIDE), "held count overflow")

endmodule

// ===== design/bmf3x3_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmf3x3_back
// Works off queued jobs one result per cycle unless the output stalls, and marks run boundaries and the image end.
// ---------------------------------------------------------------------------
`include "binary_majority_filter_3x3_assert.svh"

module bmf3x3_back
  import bmf3x3_pkg::*;
#(
  parameter int MAX_SIDE = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic [SIDE_W-1:0]     side_i,
  input  logic                  job_valid_i,
  input  job_ctl_t              job_ctl_i,
  input  logic [2*MAX_SIDE-1:0] job_snap_i,
  output logic                  job_pop_o,
  input  logic                  grp_valid_i,
  input  logic [GRP_W-1:0]      grp_size_i,
  output logic                  grp_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  filtered_pixel_o,
  output logic                  last_of_run_o,
  output logic                  end_of_image_o
);

  localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SHW = 2 * MAX_SIDE + 2;

  bk_state_e        st_q, st_d, first_st;
  job_ctl_t         ctl_q;
  logic [SHW-1:0]   sh_q;
  logic [1:0]       prev_q, cur_w, nxt_w;
  logic [CW-1:0]    col_q;
  logic             grp_open_q, grp_open_d;
  logic [GRP_W-1:0] grp_left_q, grp_left_d, left_w;
  logic             out_valid_q, filt_q, last_q, end_q;
  logic             slot_free, emit, job_end, take;
  logic             res_w, eoi_w, last_col, run_last;
  logic [2:0]       row_ok;
  logic [8:0]       fl_win;

  always_comb begin
    slot_free = !out_valid_q || out_ready_i;
    emit      = (st_q != ST_IDLE) && slot_free && (grp_open_q || grp_valid_i);

    cur_w    = sh_q[1:0];
    nxt_w    = sh_q[3:2];
    last_col = (SIDE_W'(col_q) == side_i - SIDE_W'(1));
    fl_win   = {1'b0, nxt_w[0], nxt_w[1], 1'b0, cur_w[0], cur_w[1],
                1'b0, prev_q[0], prev_q[1]};
    row_ok   = {2'b11, ctl_q.top_ok};

    first_st = ST_FLUSH;
    if (job_ctl_i.has_mid) begin
      first_st = ST_MID;
    end else if (job_ctl_i.has_edge) begin
      first_st = ST_EDGE;
    end

    res_w   = 1'b0;
    eoi_w   = 1'b0;
    job_end = 1'b0;
    st_d    = st_q;
    unique case (st_q)
      ST_IDLE: begin
        st_d = ST_IDLE;
      end
      ST_MID: begin
        res_w   = majority(ctl_q.win, {2'b11, ctl_q.mid_left_ok}, row_ok);
        job_end = !ctl_q.has_edge && !ctl_q.flush;
        if (emit) begin
          st_d = ctl_q.has_edge ? ST_EDGE : ST_FLUSH;
        end
      end
      ST_EDGE: begin
        res_w   = majority(ctl_q.win, {1'b1, ctl_q.edge_left_ok, 1'b0}, row_ok);
        job_end = !ctl_q.flush;
        if (emit) begin
          st_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        res_w   = majority(fl_win, {!last_col, 1'b1, col_q != '0},
                           {1'b0, 1'b1, side_i >= SIDE_W'(2)});
        eoi_w   = last_col;
        job_end = last_col;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
    job_end = job_end && emit;

    // load the next job without a bubble when the current one finishes
    take      = job_valid_i && ((st_q == ST_IDLE) || job_end);
    job_pop_o = take;
    if (take) begin
      st_d = first_st;
    end else if (job_end) begin
      st_d = ST_IDLE;
    end

    left_w     = grp_open_q ? grp_left_q : grp_size_i;
    grp_pop_o  = emit && !grp_open_q;
    run_last   = (left_w == GRP_W'(1));
    grp_open_d = grp_open_q;
    grp_left_d = grp_left_q;
    if (emit) begin
      grp_open_d = !run_last;
      grp_left_d = left_w - GRP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      grp_open_q  <= 1'b0;
      grp_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (clr_i) begin
      st_q        <= ST_IDLE;
      grp_open_q  <= 1'b0;
      grp_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q       <= st_d;
      grp_open_q <= grp_open_d;
      grp_left_q <= grp_left_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ctl_q  <= job_ctl_i;
      sh_q   <= {2'b00, job_snap_i};
      prev_q <= '0;
      col_q  <= '0;
    end else if (emit && (st_q == ST_FLUSH)) begin
      // advance one column along the snapshot
      sh_q   <= {2'b00, sh_q[SHW-1:2]};
      prev_q <= cur_w;
      col_q  <= col_q + CW'(1);
    end
    if (emit) begin
      filt_q <= res_w;
      last_q <= run_last;
      end_q  <= eoi_w;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_pixel_o = filt_q;
  assign last_of_run_o    = last_q;
  assign end_of_image_o   = end_q;

  `BMF_ASSERT_IMP(a_end_closes_run, clk_i, rst_ni, out_valid_q && end_q, last_q, "image end inside run")
  `BMF_ASSERT_IMP(a_run_count, clk_i, rst_ni, grp_open_q, grp_left_q != '0, "open run with zero left")
  `BMF_ASSERT_IMP(a_flush_col, clk_i, rst_ni, st_q == ST_FLUSH, SIDE_W'(col_q) < side_i, "flush column past side")

endmodule

// ===== design/binary_majority_filter_3x3.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binary_majority_filter_3x3
// 3x3 binary majority filter over a square raster image of programmable side.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                         payload
//  in       input      in_valid_i / in_ready_o           pixel_i
//  out      output     out_valid_o / out_ready_i         filtered_pixel_o, last_of_run_o,
//                                                        end_of_image_o
//  cfg      input      psel, penable, pwrite / pready    paddr, pwdata, prdata
//
//  One pixel per cycle in; the back end gives one result per cycle out unless the output stalls.
//  A row end below the top row yields two results and the image's last pixel side + 2, worked off while
//  the next pixels yield few; the input stalls only when the job or run queue fills.
//  Off the last column and row, a result is formed one row and one pixel after its pixel.
//  No clearing pass after reset. A write to side restarts the image and drops
//  any queued job and any result still held back from the final burst.
// ---------------------------------------------------------------------------
module binary_majority_filter_3x3
  import bmf3x3_pkg::*;
#(
  parameter int MAX_SIDE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              pixel_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              filtered_pixel_o,
  output logic              last_of_run_o,
  output logic              end_of_image_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int JW = $bits(job_ctl_t) + 2 * MAX_SIDE;

  logic [SIDE_W-1:0]     side_q, side_eff;
  logic                  cfg_wr;
  job_ctl_t              job_ctl_w, job_ctl_r;
  logic [2*MAX_SIDE-1:0] job_snap_w, job_snap_r;
  logic [JW-1:0]         job_rdata;
  logic                  job_push, job_full, job_pop, job_valid;
  logic                  grp_push, grp_full, grp_pop, grp_valid;
  logic [GRP_W-1:0]      grp_size_w, grp_size_r;

  always_comb begin
    pready = 1'b1;
    cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_SIDE);
    prdata = (paddr[ADDR_W-1] == REG_SIDE) ? DATA_W'(side_q) : '0;
    // clamp side into 1..MAX_SIDE
    if (side_q == '0) begin
      side_eff = SIDE_W'(1);
    end else if (side_q > SIDE_W'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = side_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RESET;
    end else if (cfg_wr) begin
      side_q <= pwdata[SIDE_W-1:0];
    end
  end

  bmf3x3_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cfg_wr),
    .side_i     (side_eff),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_i    (pixel_i),
    .job_push_o (job_push),
    .job_ctl_o  (job_ctl_w),
    .job_snap_o (job_snap_w),
    .job_full_i (job_full),
    .grp_push_o (grp_push),
    .grp_size_o (grp_size_w),
    .grp_full_i (grp_full)
  );

  bmf3x3_fifo #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (cfg_wr),
    .push_i  (job_push),
    .wdata_i ({job_ctl_w, job_snap_w}),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_rdata),
    .valid_o (job_valid)
  );

  assign {job_ctl_r, job_snap_r} = job_rdata;

  bmf3x3_fifo #(.WIDTH(GRP_W), .DEPTH(QUEUE_DEPTH)) u_grp_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (cfg_wr),
    .push_i  (grp_push),
    .wdata_i (grp_size_w),
    .full_o  (grp_full),
    .pop_i   (grp_pop),
    .rdata_o (grp_size_r),
    .valid_o (grp_valid)
  );

  bmf3x3_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .clr_i            (cfg_wr),
    .side_i           (side_eff),
    .job_valid_i      (job_valid),
    .job_ctl_i        (job_ctl_r),
    .job_snap_i       (job_snap_r),
    .job_pop_o        (job_pop),
    .grp_valid_i      (grp_valid),
    .grp_size_i       (grp_size_r),
    .grp_pop_o        (grp_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_pixel_o (filtered_pixel_o),
    .last_of_run_o    (last_of_run_o),
    .end_of_image_o   (end_of_image_o)
  );

endmodule
